/* sv/spi_pkg.sv */
`timescale 1ns / 1ps

package spi_pkg;

    localparam int CW = 32;
    localparam int DW = 33;
    localparam int PW = 66;
    localparam int SW = 67;
    localparam int RAD_W = 66;
    localparam int RW = 33;
    localparam int REM_W = 38;
    localparam int SQ_STEPS = 3;
    localparam int SQ_STAGES = 11;
    localparam int DEN_W = 66;
    localparam int SPLIT = 34;
    localparam int W = 104;
    localparam int EPS_W = 30;
    localparam int MARGIN_W = 20;

    localparam logic [EPS_W-1:0] EPS_RESET = 30'd1074;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 20'd1049;

    localparam logic REG_EPS = 1'b0;
    localparam logic REG_MARGIN = 1'b1;

    typedef logic signed [W-1:0] wide_t;

    typedef struct packed {
        logic                 nz;
        logic [DEN_W-1:0]     den;
        logic signed [SW-1:0] num_a;
        logic signed [SW-1:0] num_b;
    } side_t;

endpackage

/* sv/segment_pair_intersect.sv */
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: eight 32-bit endpoint coordinates
// m_*       out  m_tvalid/m_tready  m_tdata: crosses
// apb       in   psel/penable       parallel_eps at 0x0, end_margin at 0x4
//
// One item per cycle while no stall on m_tready holds the pipeline.
// The depth is set by the 11-stage square-root pipeline (3 root bits a stage)
// and the split wide multiplies that follow it.
// Reset clears all valid bits and loads the register defaults.
// A stall on m_tready freezes every stage; s_tready follows it directly.

module segment_pair_intersect (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // crosses, then 7 zero bits
    output logic [7:0]   m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import spi_pkg::*;

    logic en;

    logic [EPS_W-1:0]    eps_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic                cfg_wr;

    logic signed [CW-1:0] f [0:7];

    logic v1_reg, v2_reg, v3_reg, v15_reg, v16_reg, v17_reg, out_valid_reg;
    logic [SQ_STAGES-1:0] sv_reg;

    logic signed [DW-1:0] ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic signed [PW-1:0] uxux_reg, uyuy_reg, vxvx_reg, vyvy_reg;
    logic signed [PW-1:0] uxvy_reg, uyvx_reg, wxvy_reg, wyvx_reg, wxuy_reg, wyux_reg;

    logic signed [SW-1:0] la2_next, lb2_next;
    logic [RAD_W-1:0]     la2_reg, lb2_reg;
    logic signed [SW-1:0] c_reg, na_reg, nb_reg;
    logic                 nz3_reg;

    side_t side_next;
    side_t side_reg [0:SQ_STAGES-1];
    side_t sd;

    logic [RW-1:0] la_root, lb_root;

    logic [2*RW-1:0]          pll_reg;
    logic [RW+SPLIT-1:0]      lad_lo_reg, lbd_lo_reg;
    logic [RW+DEN_W-SPLIT-1:0] lad_hi_reg, lbd_hi_reg;
    logic [MARGIN_W+SPLIT-1:0] md_lo_reg;
    logic [MARGIN_W+DEN_W-SPLIT-1:0] md_hi_reg;
    logic [RW+SPLIT-1:0]      lna_lo_reg, lnb_lo_reg;
    logic signed [SW-1:0]     lna_hi_reg, lnb_hi_reg;
    logic [DEN_W-1:0]         den15_reg, den16_reg, den17_reg;
    logic                     nz15_reg, nz16_reg, nz17_reg;

    wide_t lad16_reg, lbd16_reg, md16_reg, lna16_reg, lnb16_reg;
    logic [EPS_W+SPLIT-1:0]        pe_lo_reg;
    logic [EPS_W+2*RW-SPLIT-1:0]   pe_hi_reg;

    wide_t epsp17_reg, ha17_reg, hb17_reg, md17_reg, lna17_reg, lnb17_reg;

    logic  crosses_next, crosses_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, crosses_reg};

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg    <= EPS_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_EPS:    eps_reg    <= pwdata[EPS_W-1:0];
                REG_MARGIN: margin_reg <= pwdata[MARGIN_W-1:0];
                default:    eps_reg    <= eps_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_EPS:    prdata = {{(32-EPS_W){1'b0}}, eps_reg};
            REG_MARGIN: prdata = {{(32-MARGIN_W){1'b0}}, margin_reg};
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            f[k] = s_tdata[CW*k +: CW];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            sv_reg        <= '0;
            v15_reg       <= 1'b0;
            v16_reg       <= 1'b0;
            v17_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            sv_reg        <= {sv_reg[SQ_STAGES-2:0], v3_reg};
            v15_reg       <= sv_reg[SQ_STAGES-1];
            v16_reg       <= v15_reg;
            v17_reg       <= v16_reg;
            out_valid_reg <= v17_reg;
        end
    end

    assign la2_next = SW'(uxux_reg) + SW'(uyuy_reg);
    assign lb2_next = SW'(vxvx_reg) + SW'(vyvy_reg);

    always_comb
    begin
        side_next.nz = nz3_reg;
        if (c_reg < 0)
        begin
            side_next.den   = DEN_W'(-c_reg);
            side_next.num_a = -na_reg;
            side_next.num_b = -nb_reg;
        end
        else
        begin
            side_next.den   = DEN_W'(c_reg);
            side_next.num_a = na_reg;
            side_next.num_b = nb_reg;
        end
    end

    assign sd = side_reg[SQ_STAGES-1];

    spi_sqrt u_sqrt_a (
        .clk      (clk),
        .en       (en),
        .radicand (la2_reg),
        .root     (la_root)
    );

    spi_sqrt u_sqrt_b (
        .clk      (clk),
        .en       (en),
        .radicand (lb2_reg),
        .root     (lb_root)
    );

    always_comb
    begin
        crosses_next = nz17_reg
            && !((wide_t'(den17_reg) <<< 30) < epsp17_reg)
            && (md17_reg < lna17_reg) && (lna17_reg < ha17_reg)
            && (md17_reg < lnb17_reg) && (lnb17_reg < hb17_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= {f[2][CW-1], f[2]} - {f[0][CW-1], f[0]};
            uy_reg <= {f[3][CW-1], f[3]} - {f[1][CW-1], f[1]};
            vx_reg <= {f[6][CW-1], f[6]} - {f[4][CW-1], f[4]};
            vy_reg <= {f[7][CW-1], f[7]} - {f[5][CW-1], f[5]};
            wx_reg <= {f[4][CW-1], f[4]} - {f[0][CW-1], f[0]};
            wy_reg <= {f[5][CW-1], f[5]} - {f[1][CW-1], f[1]};

            uxux_reg <= ux_reg * ux_reg;
            uyuy_reg <= uy_reg * uy_reg;
            vxvx_reg <= vx_reg * vx_reg;
            vyvy_reg <= vy_reg * vy_reg;
            uxvy_reg <= ux_reg * vy_reg;
            uyvx_reg <= uy_reg * vx_reg;
            wxvy_reg <= wx_reg * vy_reg;
            wyvx_reg <= wy_reg * vx_reg;
            wxuy_reg <= wx_reg * uy_reg;
            wyux_reg <= wy_reg * ux_reg;

            la2_reg <= la2_next[RAD_W-1:0];
            lb2_reg <= lb2_next[RAD_W-1:0];
            c_reg   <= SW'(uxvy_reg) - SW'(uyvx_reg);
            na_reg  <= SW'(wxvy_reg) - SW'(wyvx_reg);
            nb_reg  <= SW'(wxuy_reg) - SW'(wyux_reg);
            nz3_reg <= (la2_next != 0) && (lb2_next != 0);

            side_reg[0] <= side_next;
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            // split wide products into partials
            pll_reg    <= la_root * lb_root;
            lad_lo_reg <= la_root * sd.den[SPLIT-1:0];
            lad_hi_reg <= la_root * sd.den[DEN_W-1:SPLIT];
            lbd_lo_reg <= lb_root * sd.den[SPLIT-1:0];
            lbd_hi_reg <= lb_root * sd.den[DEN_W-1:SPLIT];
            md_lo_reg  <= margin_reg * sd.den[SPLIT-1:0];
            md_hi_reg  <= margin_reg * sd.den[DEN_W-1:SPLIT];
            lna_lo_reg <= la_root * sd.num_a[SPLIT-1:0];
            lna_hi_reg <= $signed({1'b0, la_root}) * $signed(sd.num_a[SW-1:SPLIT]);
            lnb_lo_reg <= lb_root * sd.num_b[SPLIT-1:0];
            lnb_hi_reg <= $signed({1'b0, lb_root}) * $signed(sd.num_b[SW-1:SPLIT]);
            den15_reg  <= sd.den;
            nz15_reg   <= sd.nz;

            lad16_reg <= (wide_t'(lad_hi_reg) <<< SPLIT) + wide_t'(lad_lo_reg);
            lbd16_reg <= (wide_t'(lbd_hi_reg) <<< SPLIT) + wide_t'(lbd_lo_reg);
            md16_reg  <= (wide_t'(md_hi_reg) <<< SPLIT) + wide_t'(md_lo_reg);
            lna16_reg <= (wide_t'(lna_hi_reg) <<< SPLIT) + wide_t'(lna_lo_reg);
            lnb16_reg <= (wide_t'(lnb_hi_reg) <<< SPLIT) + wide_t'(lnb_lo_reg);
            pe_lo_reg <= eps_reg * pll_reg[SPLIT-1:0];
            pe_hi_reg <= eps_reg * pll_reg[2*RW-1:SPLIT];
            den16_reg <= den15_reg;
            nz16_reg  <= nz15_reg;

            epsp17_reg <= (wide_t'(pe_hi_reg) <<< SPLIT) + wide_t'(pe_lo_reg);
            ha17_reg   <= lad16_reg - md16_reg;
            hb17_reg   <= lbd16_reg - md16_reg;
            md17_reg   <= md16_reg;
            lna17_reg  <= lna16_reg;
            lnb17_reg  <= lnb16_reg;
            den17_reg  <= den16_reg;
            nz17_reg   <= nz16_reg;

            crosses_reg <= crosses_next;
        end
    end

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_valid_advances: assert property (@(posedge clk) disable iff (!rst_n)
        en && v1_reg |=> v2_reg)
        else $error("valid bit lost between first stages");

    a_eps_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && (paddr[2] == REG_EPS) |=> eps_reg == $past(pwdata[EPS_W-1:0]))
        else $error("parallel_eps write not applied");

    a_margin_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && (paddr[2] == REG_MARGIN) |=> margin_reg == $past(pwdata[MARGIN_W-1:0]))
        else $error("end_margin write not applied");

endmodule

/* sv/spi_sqrt.sv */
`timescale 1ns / 1ps

module spi_sqrt (
    input  logic                      clk,
    input  logic                      en,
    input  logic [spi_pkg::RAD_W-1:0] radicand,
    output logic [spi_pkg::RW-1:0]    root
);
    import spi_pkg::*;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [RW-1:0]    root;
        logic [RAD_W-1:0] rad;
    } sq_t;

    function automatic sq_t sq_step(input sq_t s);
        sq_t              r;
        logic [REM_W-1:0] trial;
        r = s;
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            r.rem = {r.rem[REM_W-3:0], r.rad[RAD_W-1 -: 2]};
            r.rad = {r.rad[RAD_W-3:0], 2'b00};
            trial = {{(REM_W-RW-2){1'b0}}, r.root, 2'b01};
            if (r.rem >= trial)
            begin
                r.rem  = r.rem - trial;
                r.root = {r.root[RW-2:0], 1'b1};
            end
            else
            begin
                r.root = {r.root[RW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    sq_t stage_reg [0:SQ_STAGES-1];
    sq_t first_next;

    assign first_next = '{rem: '0, root: '0, rad: radicand};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= sq_step(first_next);
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                stage_reg[k] <= sq_step(stage_reg[k-1]);
            end
        end
    end

    assign root = stage_reg[SQ_STAGES-1].root;

endmodule
